// ===== rtl/sto_pkg.sv =====
// Shared types and constants for the sphere versus tetrahedron node overlap block.
package sto_pkg;

    localparam int NODE_LANES = 4;
    localparam int COORD_BITS = 21;
    localparam int IDX_BITS   = 17;
    localparam int NODE_BITS  = 16;
    localparam int POS_BITS   = 3 * COORD_BITS;
    localparam int ABS_BITS   = COORD_BITS;
    localparam int SQ_BITS    = 2 * ABS_BITS;
    localparam int D2_BITS    = SQ_BITS + 2;
    localparam int RAD_BITS   = 20;
    localparam int R2_BITS    = 2 * RAD_BITS;
    localparam int ROOT_BITS  = D2_BITS / 2;
    localparam int REM_BITS   = D2_BITS + 2;
    localparam int CNT_BITS   = 3;

    localparam logic [IDX_BITS-1:0] MAX_NODES = 17'd65536;

    // Input tdata layout, lowest field first
    localparam int IN_MESH_LSB = 0;
    localparam int IN_TET_LSB  = 16;
    localparam int IN_IDX_LSB  = 32;
    localparam int IN_POS_LSB  = IN_IDX_LSB + NODE_LANES * IDX_BITS;
    localparam int IN_BITS     = IN_POS_LSB + NODE_LANES * POS_BITS;
    localparam int OUT_BITS    = 128;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 21;
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SPHERE_ENABLE = 3'd0,
        CFG_CENTER_X      = 3'd1,
        CFG_CENTER_Y      = 3'd2,
        CFG_CENTER_Z      = 3'd3,
        CFG_SPHERE_RADIUS = 3'd4,
        CFG_NODE_COUNT    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0]                          mesh_index;
        logic [15:0]                          tet_index;
        logic [NODE_LANES-1:0][NODE_BITS-1:0] node;
    } pass_t;

    typedef struct packed {
        logic  valid;
        pass_t pass;
    } tag_t;

    typedef struct packed {
        pass_t                pass;
        logic [NODE_LANES-1:0] mask;
        logic [CNT_BITS-1:0]  count;
    } side_t;

    typedef struct packed {
        logic                valid;
        side_t               side;
        logic [D2_BITS-1:0]  min_d2;
    } sq_req_t;

    typedef struct packed {
        side_t                side;
        logic [ROOT_BITS-1:0] root;
    } out_t;

    typedef struct packed {
        logic valid;
        out_t data;
    } sq_res_t;

endpackage

// ===== rtl/sto_lane.sv =====
// One distance lane: squared distance from a node position to the sphere center.
module sto_lane (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [sto_pkg::POS_BITS-1:0]    pos,
    input  logic [sto_pkg::COORD_BITS-1:0]  center_x,
    input  logic [sto_pkg::COORD_BITS-1:0]  center_y,
    input  logic [sto_pkg::COORD_BITS-1:0]  center_z,
    output logic [sto_pkg::D2_BITS-1:0]     d2
);
    import sto_pkg::*;

    logic [COORD_BITS-1:0] pt [3];
    logic [COORD_BITS-1:0] ct [3];
    logic [COORD_BITS:0]   diff [3];
    logic [ABS_BITS-1:0]   abs_next [3];
    logic [ABS_BITS-1:0]   abs_reg [3];
    logic [SQ_BITS-1:0]    sq_reg [3];
    logic [D2_BITS-1:0]    d2_reg;

    assign ct[0] = center_x;
    assign ct[1] = center_y;
    assign ct[2] = center_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            pt[a]   = pos[a*COORD_BITS +: COORD_BITS];
            diff[a] = {pt[a][COORD_BITS-1], pt[a]} - {ct[a][COORD_BITS-1], ct[a]};
            // magnitude of a one-bit-wider difference always fits COORD_BITS
            abs_next[a] = diff[a][COORD_BITS] ? ABS_BITS'(-diff[a]) : ABS_BITS'(diff[a]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                abs_reg[a] <= abs_next[a];
                sq_reg[a]  <= abs_reg[a] * abs_reg[a];
            end
            d2_reg <= D2_BITS'(sq_reg[0]) + D2_BITS'(sq_reg[1]) + D2_BITS'(sq_reg[2]);
        end
    end

    assign d2 = d2_reg;

endmodule

// ===== rtl/sto_merge.sv =====
// Merge of the four lanes: inside mask, count and smallest squared distance.
module sto_merge (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         en,
    input  sto_pkg::tag_t                                tag,
    input  logic [sto_pkg::NODE_LANES-1:0][sto_pkg::D2_BITS-1:0] d2,
    input  logic [sto_pkg::R2_BITS-1:0]                  r2,
    output sto_pkg::sq_req_t                             req
);
    import sto_pkg::*;

    logic                  vld1_reg;
    pass_t                 pass1_reg;
    logic [NODE_LANES-1:0] mask_next;
    logic [NODE_LANES-1:0] mask1_reg;
    logic [D2_BITS-1:0]    min01_reg;
    logic [D2_BITS-1:0]    min23_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic                  vld2_reg;
    side_t                 side2_reg;
    logic [D2_BITS-1:0]    min2_reg;

    always_comb begin
        for (int k = 0; k < NODE_LANES; k++) begin
            mask_next[k] = d2[k] <= D2_BITS'(r2);
        end
        count_next = '0;
        for (int k = 0; k < NODE_LANES; k++) begin
            count_next = count_next + CNT_BITS'(mask1_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= tag.valid;
            // drop the request when no node is inside
            vld2_reg <= vld1_reg && (mask1_reg != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pass1_reg <= tag.pass;
            mask1_reg <= mask_next;
            min01_reg <= (d2[1] < d2[0]) ? d2[1] : d2[0];
            min23_reg <= (d2[3] < d2[2]) ? d2[3] : d2[2];
            side2_reg.pass  <= pass1_reg;
            side2_reg.mask  <= mask1_reg;
            side2_reg.count <= count_next;
            min2_reg <= (min23_reg < min01_reg) ? min23_reg : min01_reg;
        end
    end

    assign req.valid  = vld2_reg;
    assign req.side   = side2_reg;
    assign req.min_d2 = min2_reg;

endmodule

// ===== rtl/sto_isqrt.sv =====
// Pipelined integer square root, one root bit resolved per stage.
module sto_isqrt (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  sto_pkg::sq_req_t req,
    output sto_pkg::sq_res_t res
);
    import sto_pkg::*;

    localparam int STAGES = ROOT_BITS;

    logic                 vld_reg  [STAGES];
    logic [REM_BITS-1:0]  rem_reg  [STAGES];
    logic [ROOT_BITS-1:0] root_reg [STAGES];
    side_t                side_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        localparam int B = STAGES - 1 - s;
        logic                 src_vld;
        logic [REM_BITS-1:0]  src_rem;
        logic [ROOT_BITS-1:0] src_root;
        side_t                src_side;
        logic [REM_BITS-1:0]  trial;
        logic                 take;

        if (s == 0) begin : g_head
            assign src_vld  = req.valid;
            assign src_rem  = REM_BITS'(req.min_d2);
            assign src_root = '0;
            assign src_side = req.side;
        end else begin : g_body
            assign src_vld  = vld_reg[s-1];
            assign src_rem  = rem_reg[s-1];
            assign src_root = root_reg[s-1];
            assign src_side = side_reg[s-1];
        end

        // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
        assign trial = (REM_BITS'(src_root) << (B + 1)) | (REM_BITS'(1) << (2 * B));
        assign take  = src_rem >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= src_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= take ? src_rem - trial : src_rem;
                root_reg[s] <= take ? (src_root | (ROOT_BITS'(1) << B)) : src_root;
                side_reg[s] <= src_side;
            end
        end
    end

    assign res.valid     = vld_reg[STAGES-1];
    assign res.data.side = side_reg[STAGES-1];
    assign res.data.root = root_reg[STAGES-1];

endmodule

// ===== rtl/sphere_tet_node_overlap.sv =====
// Top level of the sphere versus tetrahedron node overlap block.
//
// Tests the four nodes of each tetrahedron in parallel against the configured sphere;
// a result passes the distance lanes, the merge, the square root and output register.
// Tets that are inactive, carry a bad node index, meet a disabled or zero-radius
// sphere, or touch no node produce nothing. The rate is one tet per cycle while
// s_tready is high, set by the four distance lanes and the 22-stage root pipeline,
// each of which takes a new request every enabled cycle. When the result side stalls,
// one more result is caught in a skid register and s_tready falls until it drains.
// Configuration must be written only while the block is idle, which it does not enforce.
module sphere_tet_node_overlap (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sto_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [sto_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // mesh_index, tet_index, node_index_0..3, node_pos_0..3
    input  logic [sto_pkg::IN_BITS-1:0]         s_tdata,
    // tet_active
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_mesh_index, out_tet_index, out_node_0..3, overlap_mask, overlap_count,
    // min_distance, zero fill
    output logic [sto_pkg::OUT_BITS-1:0]        m_tdata
);
    import sto_pkg::*;

    logic                  enable_reg;
    logic [COORD_BITS-1:0] center_x_reg;
    logic [COORD_BITS-1:0] center_y_reg;
    logic [COORD_BITS-1:0] center_z_reg;
    logic [RAD_BITS-1:0]   radius_reg;
    logic [IDX_BITS-1:0]   node_count_reg;
    logic [R2_BITS-1:0]    r2_reg;

    logic                  en;
    logic                  accept;
    logic [IDX_BITS-1:0]   limit;
    logic [NODE_LANES-1:0] idx_ok;
    logic                  alive;
    pass_t                 pass_in;
    tag_t                  tag_reg [3];
    logic [NODE_LANES-1:0][D2_BITS-1:0] d2;
    sq_req_t               req;
    sq_res_t               res;

    logic                  out_ready;
    logic                  m_tvalid_reg;
    out_t                  out_reg;
    logic                  skid_valid_reg;
    out_t                  skid_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg     <= 1'b0;
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            center_z_reg   <= '0;
            radius_reg     <= '0;
            node_count_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SPHERE_ENABLE: enable_reg     <= cfg_wdata[0];
                CFG_CENTER_X:      center_x_reg   <= cfg_wdata[COORD_BITS-1:0];
                CFG_CENTER_Y:      center_y_reg   <= cfg_wdata[COORD_BITS-1:0];
                CFG_CENTER_Z:      center_z_reg   <= cfg_wdata[COORD_BITS-1:0];
                CFG_SPHERE_RADIUS: radius_reg     <= cfg_wdata[RAD_BITS-1:0];
                CFG_NODE_COUNT:    node_count_reg <= cfg_wdata[IDX_BITS-1:0];
                default: ;
            endcase
        end
    end

    // squared radius is first used in the merge, after the lane stages
    always_ff @(posedge aclk) begin
        r2_reg <= radius_reg * radius_reg;
    end

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        limit = (node_count_reg > MAX_NODES) ? MAX_NODES : node_count_reg;
        pass_in.mesh_index = s_tdata[IN_MESH_LSB +: 16];
        pass_in.tet_index  = s_tdata[IN_TET_LSB +: 16];
        for (int k = 0; k < NODE_LANES; k++) begin
            idx_ok[k] = !s_tdata[IN_IDX_LSB + k*IDX_BITS + IDX_BITS - 1]
                && ({1'b0, s_tdata[IN_IDX_LSB + k*IDX_BITS +: NODE_BITS]} < limit);
            pass_in.node[k] = s_tdata[IN_IDX_LSB + k*IDX_BITS +: NODE_BITS];
        end
        alive = s_tuser && enable_reg && (radius_reg != '0) && (idx_ok == '1);
    end

    // Request tag follows the three lane stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg[0].valid <= 1'b0;
            tag_reg[1].valid <= 1'b0;
            tag_reg[2].valid <= 1'b0;
        end else if (en) begin
            tag_reg[0].valid <= accept && alive;
            tag_reg[1].valid <= tag_reg[0].valid;
            tag_reg[2].valid <= tag_reg[1].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0].pass <= pass_in;
            tag_reg[1].pass <= tag_reg[0].pass;
            tag_reg[2].pass <= tag_reg[1].pass;
        end
    end

    for (genvar k = 0; k < NODE_LANES; k++) begin : g_lane
        sto_lane u_lane (
            .aclk     (aclk),
            .en       (en),
            .pos      (s_tdata[IN_POS_LSB + k*POS_BITS +: POS_BITS]),
            .center_x (center_x_reg),
            .center_y (center_y_reg),
            .center_z (center_z_reg),
            .d2       (d2[k])
        );
    end

    sto_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .tag     (tag_reg[2]),
        .d2      (d2),
        .r2      (r2_reg),
        .req     (req)
    );

    sto_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .req     (req),
        .res     (res)
    );

    // Output register with skid: on a stall the pipeline advances until the skid is full
    assign out_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_tvalid_reg   <= skid_valid_reg || res.valid;
            skid_valid_reg <= 1'b0;
        end else if (en && res.valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : res.data;
        end else if (en) begin
            skid_reg <= res.data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000,
                       out_reg.root,
                       out_reg.side.count,
                       out_reg.side.mask,
                       out_reg.side.pass.node[3],
                       out_reg.side.pass.node[2],
                       out_reg.side.pass.node[1],
                       out_reg.side.pass.node[0],
                       out_reg.side.pass.tet_index,
                       out_reg.side.pass.mesh_index};

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_tvalid_reg)
        else $error("skid holds a result while output is empty");

    a_skid_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !out_ready |=> skid_valid_reg && $stable(skid_reg))
        else $error("skid result lost while output stalled");

    a_count_matches_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (out_reg.side.mask != '0)
            && ($countones(out_reg.side.mask) == int'(out_reg.side.count)))
        else $error("overlap count disagrees with mask");

    a_no_accept_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !accept)
        else $error("request taken while skid is full");
`endif

endmodule
